@@ src/frp_pkg.sv @@
package frp_pkg;
    localparam int RING_DEPTH    = 32;
    localparam int RING_AW       = $clog2(RING_DEPTH);
    localparam int FILL_W        = RING_AW + 1;
    localparam int LATE_LIMIT_MS = 250;
    localparam logic [25:0] MS_SCALED = 26'd65536000;
    localparam logic [9:0]  RATE_RESET = 10'd60;
    localparam logic [15:0] NUM_HALF = 16'd15000;
    localparam logic [15:0] NUM_FULL = 16'd31000;

    typedef struct packed {
        logic [31:0] frame_count;
        logic [31:0] waited_total_ms;
        logic [6:0]  load_percent;
        logic [14:0] measured_rate;
        logic [9:0]  skips_last_period;
        logic        skip_next;
        logic [9:0]  wait_ms;
    } result_t;
endpackage

@@ src/frame_rate_pacer.sv @@
// frame_rate_pacer: paces display frames from a millisecond time stamp.
// s_axis: one item per frame, tdata = now_ms (32 bits), tuser = kind
//   (0 frame boundary, 1 restart pacing at now_ms).
// m_axis: one result item per input item, tdata packs wait_ms, skip_next,
//   skips_last_period, measured_rate, load_percent, waited_total_ms,
//   frame_count from the lowest bit up.
// cfg_we/cfg_data write target_rate (0 = non-wait mode); write only when idle,
// s_axis_tready is low while cfg_we is high.
// each item runs through an idle state, the pacing step, two ring read steps,
// a 32-step restoring rate divide on the shared subtract unit, a sum of the
// 16 idle entries read one a cycle, the multiply and load steps and an output
// step. the period step divide is precomputed at a non-zero register write by
// the same 26-step restoring divider.
// s_axis_tready is low from acceptance until the result is sent; the result
// stays in the output register while m_axis_tready is low and the block is
// blocked meanwhile. a non-zero register write runs the period step divide
// before the next item can be accepted.
// reset loads rate 60 and its step and clears the counters and pacing state; rings read as zero via valid bits.
module frame_rate_pacer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [9:0]   cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // now_ms
    input  logic         s_axis_tuser,   // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata    // wait_ms, skip_next, skips_last_period,
                                         // measured_rate, load_percent,
                                         // waited_total_ms, frame_count, zeros
);
    import frp_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_PDIV = 4'd1, S_PACE = 4'd2,
                           S_RD0 = 4'd3, S_RD1 = 4'd4, S_RDIV = 4'd5,
                           S_SUM = 4'd6, S_MUL = 4'd7, S_LOAD = 4'd8,
                           S_OUT = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [9:0]  rate_reg;
    logic [31:0] last_reg, frames_reg, idle_total_reg;
    logic [25:0] accum_reg, step_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [9:0]  phase_reg, skips_run_reg, skips_lat_reg;
    logic        skip_reg;
    logic        kind_reg;
    logic [31:0] now_reg;
    logic [9:0]  wait_out_reg;

    logic [31:0] stamp_mem [RING_DEPTH];
    logic [9:0]  idle_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] sv_reg, iv_reg;
    logic [31:0] stamp_rd_reg;
    logic [9:0]  idle_rd_reg;
    logic [31:0] stamp_a_reg;

    // shared restoring divider
    logic [31:0] rem_reg, quo_reg, dvs_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] trial;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    logic [14:0] mrate_reg;
    logic [13:0] sum_reg;
    logic [23:0] prod_reg;
    logic [6:0]  load_reg;
    logic [16:0] used_prod;
    logic [RING_AW-1:0] rd_addr;
    logic        full;
    result_t     res;

    assign full = fill_reg[FILL_W-1];
    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_we;

    // divide by 160 as a shift by 5 and a multiply by 205/1024, exact below 16000
    assign used_prod = {8'd0, prod_reg[13:5]} * 17'd205;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    if (cfg_data != 10'd0)
                        state_next = S_PDIV;
                end
                else if (s_axis_tvalid)
                    state_next = S_PACE;
            end
            S_PDIV: if (cnt_reg == 6'd0) state_next = S_IDLE;
            S_PACE: state_next = S_RD0;
            S_RD0:  state_next = S_RD1;
            S_RD1:  state_next = S_RDIV;
            S_RDIV: if (cnt_reg == 6'd0) state_next = S_SUM;
            S_SUM:  if (cnt_reg == 6'd0) state_next = S_MUL;
            S_MUL:  state_next = S_LOAD;
            S_LOAD: state_next = S_OUT;
            S_OUT:  if (m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rd_addr = '0;
        case (state_reg)
            S_PACE: rd_addr = fill_reg[RING_AW-1:0] - 1'b1;
            S_RD0:  rd_addr = full ? fill_reg[RING_AW-1:0]
                                   : fill_reg[RING_AW-1:0] - RING_AW'(16);
            S_RDIV, S_SUM: rd_addr = RING_AW'(cnt_reg[3:0]);
            default: rd_addr = '0;
        endcase
    end

    // ring reads, registered
    always_ff @(posedge clk)
    begin
        stamp_rd_reg <= stamp_mem[rd_addr];
        idle_rd_reg  <= idle_mem[rd_addr];
    end

    logic [31:0] stamp_v;
    logic [9:0]  idle_v;
    logic [RING_AW-1:0] rd_addr_d;
    always_ff @(posedge clk) rd_addr_d <= rd_addr;
    assign stamp_v = sv_reg[rd_addr_d] ? stamp_rd_reg : 32'd0;
    assign idle_v  = iv_reg[rd_addr_d] ? idle_rd_reg : 10'd0;

    // pacing step (combinational part: accumulator add, elapsed time and lateness compares)
    logic [FILL_W-1:0] fill_inc;
    logic [25:0] acc_new;
    logic [9:0]  wt;
    logic [31:0] elp, dly_raw, dly;
    logic        late, skip_new;
    always_comb
    begin
        fill_inc = fill_reg + 1'b1;
        if (fill_inc == '0) fill_inc = FILL_W'(RING_DEPTH);
        acc_new = {10'd0, accum_reg[15:0]} + step_reg;
        wt = acc_new[25:16];
        elp = now_reg - last_reg;
        late = elp >= {22'd0, wt};
        dly_raw = elp - {22'd0, wt};
        dly = (dly_raw >= 32'(LATE_LIMIT_MS)) ? 32'd0 : dly_raw;
        skip_new = dly >= 32'({wt, 1'b0}) + 32'(wt);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PACE && !kind_reg)
        begin
            stamp_mem[fill_reg[RING_AW-1:0]] <= now_reg;
            idle_mem[fill_inc[RING_AW-1:0]] <= (rate_reg != 0 && !late) ? elp[9:0] : 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rate_reg <= RATE_RESET;
            last_reg <= '0; frames_reg <= '0; idle_total_reg <= '0;
            accum_reg <= '0; step_reg <= 26'(MS_SCALED / 60);
            fill_reg <= '0; phase_reg <= '0; skips_run_reg <= '0;
            skips_lat_reg <= '0; skip_reg <= 1'b0;
            sv_reg <= '0; iv_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_we)
                    begin
                        rate_reg <= cfg_data;
                        skip_reg <= 1'b0; skips_run_reg <= '0; skips_lat_reg <= '0;
                        idle_total_reg <= '0; frames_reg <= '0; fill_reg <= '0;
                        phase_reg <= '0;
                        if (cfg_data != 10'd0)
                        begin
                            accum_reg <= '0;
                            rem_reg <= '0;
                            quo_reg <= {MS_SCALED, 6'd0};
                            dvs_reg <= {22'd0, cfg_data};
                            cnt_reg <= 6'd25;
                        end
                    end
                    else if (s_axis_tvalid)
                    begin
                        kind_reg <= s_axis_tuser;
                        now_reg <= s_axis_tdata;
                    end
                end
                S_PDIV:
                begin
                    if (!trial[32]) begin rem_reg <= trial[31:0]; quo_reg <= {quo_reg[30:0], 1'b1}; end
                    else begin rem_reg <= {rem_reg[30:0], quo_reg[31]}; quo_reg <= {quo_reg[30:0], 1'b0}; end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 6'd0)
                        step_reg <= !trial[32] ? {quo_reg[24:0], 1'b1} : {quo_reg[24:0], 1'b0};
                end
                S_PACE:
                begin
                    wait_out_reg <= '0;
                    if (kind_reg)
                    begin
                        last_reg <= now_reg; skip_reg <= 1'b0;
                        skips_run_reg <= '0; skips_lat_reg <= '0;
                    end
                    else
                    begin
                        sv_reg[fill_reg[RING_AW-1:0]] <= 1'b1;
                        iv_reg[fill_inc[RING_AW-1:0]] <= 1'b1;
                        fill_reg <= fill_inc;
                        frames_reg <= frames_reg + 1'b1;
                        if (rate_reg != 0)
                        begin
                            phase_reg <= ({1'b0, phase_reg} + 11'd1 >= {1'b0, rate_reg})
                                         ? 10'd0 : phase_reg + 1'b1;
                            accum_reg <= acc_new;
                            if (late)
                            begin
                                skip_reg <= skip_new;
                                if (phase_reg == 0)
                                begin
                                    skips_lat_reg <= skips_run_reg;
                                    skips_run_reg <= {9'd0, skip_new};
                                end
                                else if (skip_new && skips_run_reg != 10'h3ff)
                                    skips_run_reg <= skips_run_reg + 1'b1;
                                last_reg <= now_reg - dly;
                            end
                            else
                            begin
                                if (phase_reg == 0)
                                begin
                                    skips_lat_reg <= skips_run_reg;
                                    skips_run_reg <= '0;
                                end
                                idle_total_reg <= idle_total_reg + elp;
                                skip_reg <= 1'b0;
                                last_reg <= last_reg + {22'd0, wt};
                                wait_out_reg <= wt - elp[9:0];
                            end
                        end
                    end
                end
                S_RD0:
                begin
                    // newest stamp: the one just written for a frame, else the newest stored one
                    stamp_a_reg <= kind_reg ? stamp_v : now_reg;
                end
                S_RD1:
                begin
                    // stamp_v holds the oldest stamp of the span here
                    dvs_reg <= stamp_a_reg - stamp_v;
                    quo_reg <= 32'(full ? NUM_FULL : NUM_HALF)
                               + ((stamp_a_reg - stamp_v) >> 1);
                    rem_reg <= '0;
                    cnt_reg <= 6'd31;
                end
                S_RDIV:
                begin
                    if (!trial[32]) begin rem_reg <= trial[31:0]; quo_reg <= {quo_reg[30:0], 1'b1}; end
                    else begin rem_reg <= {rem_reg[30:0], quo_reg[31]}; quo_reg <= {quo_reg[30:0], 1'b0}; end
                    if (cnt_reg == 6'd0)
                    begin
                        mrate_reg <= (fill_reg < FILL_W'(16) || dvs_reg == 32'd0) ? 15'd0
                                     : (!trial[32] ? {quo_reg[13:0], 1'b1} : {quo_reg[13:0], 1'b0});
                        cnt_reg <= 6'd16;
                        sum_reg <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                S_SUM:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg != 6'd16) sum_reg <= sum_reg + {4'd0, idle_v};
                end
                S_MUL:  prod_reg <= sum_reg * rate_reg;
                S_LOAD:
                begin
                    load_reg <= (fill_reg < FILL_W'(16) || prod_reg >= 24'd16000) ? 7'd0
                                : 7'd100 - used_prod[16:10];
                end
                S_OUT:  ;
                default: ;
            endcase
        end
    end

    assign res.wait_ms = wait_out_reg;
    assign res.skip_next = skip_reg;
    assign res.skips_last_period = skips_lat_reg;
    assign res.measured_rate = mrate_reg;
    assign res.load_percent = load_reg;
    assign res.waited_total_ms = idle_total_reg;
    assign res.frame_count = frames_reg;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata = {5'd0, res.frame_count, res.waited_total_ms, res.load_percent,
                           res.measured_rate, res.skips_last_period, res.skip_next,
                           res.wait_ms};

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> load_reg <= 7'd100) else $error("load out of range");
`endif
endmodule
